// ===== src/spcc_pkg.sv =====
// Shared types, widths and codes of the sprite pool circle collision block.
package spcc_pkg;

  localparam int SLOT_W    = 8;
  localparam int POS_W     = 20;
  localparam int RAD_W     = 16;
  localparam int TYPE_W    = 16;
  localparam int SLOT_SPAN = 1 << SLOT_W;
  localparam int DIFF_W    = POS_W + 1;
  localparam int RSUM_W    = RAD_W + 1;
  localparam int SQ_W      = 2 * RSUM_W;
  localparam int SUM_W     = SQ_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [SLOT_W-1:0]        slot;
    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  y_pos;
    logic [RAD_W-1:0]         radius;
    logic [TYPE_W-1:0]        type_mask;
    logic                     live;
    logic                     collide_enable;
    logic [SLOT_W-1:0]        probe_slot;
    logic                     probe_in_table;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [RAD_W-1:0]        radius;
    logic [TYPE_W-1:0]       types;
    logic                    live;
    logic                    collide;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Magnitude of a - b; one bit wider than the operands so it never wraps.
  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[DIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

endpackage

// ===== src/spcc_ifs.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface spcc_in_if;
  logic                valid;
  logic                ready;
  spcc_pkg::in_item_t  payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface spcc_out_if;
  logic                valid;
  logic                ready;
  spcc_pkg::out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== src/sprite_pool_circle_collision.sv =====
// Sprite table in one synchronous memory with a pipelined circle collision scan.
//
// Input beats arrive on in_chan. A write beat (operation = write) stores one
// sprite entry; a slot beyond the table is dropped. A query beat scans the
// table in ascending slot order and reports the lowest live, enabled entry
// of a matching type, other than the probe's own slot, whose circle touches
// the probe's circle. Every input beat yields exactly one beat on out_chan;
// a write and a query without a hit both report hit = 0, hit_slot = 0.
// The scan reads one entry per cycle from the entry memory and stops early on
// a hit; a write goes straight to the response stage. One item is worked on at a
// time; the next is accepted in the cycle after the current result has moved
// to the output register, even while that register waits for out_chan.ready.
// A stalled receiver only holds the finished result; a further item waits in
// the response stage until the output register frees up.
// Reset clears the per-entry valid bits, so every slot reads as not live
// until written; no clearing pass is needed.
module sprite_pool_circle_collision #(
  parameter int POOL_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  spcc_in_if.sink           in_chan,
  spcc_out_if.source        out_chan
);

  // Only slots reachable through the slot field can ever hold an entry.
  localparam int MEM_DEPTH = (POOL_SIZE < spcc_pkg::SLOT_SPAN) ? POOL_SIZE
                                                               : spcc_pkg::SLOT_SPAN;
  localparam int IDX_W = $clog2(MEM_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_DEPTH - 1);

  spcc_pkg::entry_t mem [MEM_DEPTH];
  spcc_pkg::entry_t rd_data_r;
  logic [MEM_DEPTH-1:0] vld_r;
  logic                 vld_rd_r;

  spcc_pkg::state_t state_r, state_nxt;

  logic accept, wr_en, load_out, scan_end, s3_hit, s3_last;
  logic [IDX_W-1:0] wr_idx;
  spcc_pkg::entry_t wr_entry;

  logic                            q_valid_unused;
  logic signed [spcc_pkg::POS_W-1:0] q_x_r, q_y_r;
  logic [spcc_pkg::RAD_W-1:0]      q_rad_r;
  logic [spcc_pkg::TYPE_W-1:0]     q_mask_r;
  logic [spcc_pkg::SLOT_W-1:0]     q_probe_r;
  logic                            q_skip_r;

  logic             iss_act_r;
  logic [IDX_W-1:0] iss_idx_r;
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0] s1_idx_r, s2_idx_r, s3_idx_r;

  logic                        s2_pre_r;
  logic [spcc_pkg::DIFF_W-1:0] s2_dx_r, s2_dy_r;
  logic [spcc_pkg::RSUM_W-1:0] s2_rsum_r;
  logic                        s3_ok_r;
  logic [spcc_pkg::SQ_W-1:0]   s3_sqdx_r, s3_sqdy_r, s3_sqr_r;
  logic [spcc_pkg::SUM_W-1:0]  dist_sum;

  spcc_pkg::out_item_t res_r, out_data_r;
  logic                out_valid_r, out_valid_nxt;

  logic s2_pre_nxt;

  assign accept   = in_chan.valid && in_chan.ready;
  assign wr_idx   = in_chan.payload.slot[IDX_W-1:0];
  assign wr_en    = accept && (in_chan.payload.operation == spcc_pkg::OP_WRITE) &&
                    ({1'b0, in_chan.payload.slot} < (spcc_pkg::SLOT_W + 1)'(MEM_DEPTH));
  assign q_valid_unused = 1'b0;

  always_comb begin
    wr_entry.x       = in_chan.payload.x_pos;
    wr_entry.y       = in_chan.payload.y_pos;
    wr_entry.radius  = in_chan.payload.radius;
    wr_entry.types   = in_chan.payload.type_mask;
    wr_entry.live    = in_chan.payload.live;
    wr_entry.collide = in_chan.payload.collide_enable;
  end

  // Entry memory: one write port, one registered read port driven by the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    rd_data_r <= mem[iss_idx_r];
    vld_rd_r  <= vld_r[iss_idx_r];
  end

  // Query operands are held for the whole scan.
  always_ff @(posedge clk) begin
    if (accept && in_chan.payload.operation == spcc_pkg::OP_QUERY) begin
      q_x_r     <= in_chan.payload.x_pos;
      q_y_r     <= in_chan.payload.y_pos;
      q_rad_r   <= in_chan.payload.radius;
      q_mask_r  <= in_chan.payload.type_mask;
      q_probe_r <= in_chan.payload.probe_slot;
      q_skip_r  <= in_chan.payload.probe_in_table;
    end
  end

  assign s2_pre_nxt = vld_rd_r && rd_data_r.live && rd_data_r.collide &&
                      ((rd_data_r.types & q_mask_r) != '0) &&
                      !(q_skip_r && (spcc_pkg::SLOT_W'(s1_idx_r) == q_probe_r));

  // Scan datapath: distances, then squares, then the final compare.
  always_ff @(posedge clk) begin
    s1_idx_r  <= iss_idx_r;
    s2_idx_r  <= s1_idx_r;
    s3_idx_r  <= s2_idx_r;
    s2_pre_r  <= s2_pre_nxt;
    s2_dx_r   <= spcc_pkg::abs_diff(rd_data_r.x, q_x_r);
    s2_dy_r   <= spcc_pkg::abs_diff(rd_data_r.y, q_y_r);
    s2_rsum_r <= {1'b0, rd_data_r.radius} + {1'b0, q_rad_r};
    // After the axis reject both distances fit in the radius-sum width.
    s3_ok_r   <= s2_pre_r &&
                 (s2_dx_r <= spcc_pkg::DIFF_W'(s2_rsum_r)) &&
                 (s2_dy_r <= spcc_pkg::DIFF_W'(s2_rsum_r));
    s3_sqdx_r <= s2_dx_r[spcc_pkg::RSUM_W-1:0] * s2_dx_r[spcc_pkg::RSUM_W-1:0];
    s3_sqdy_r <= s2_dy_r[spcc_pkg::RSUM_W-1:0] * s2_dy_r[spcc_pkg::RSUM_W-1:0];
    s3_sqr_r  <= s2_rsum_r * s2_rsum_r;
  end

  assign dist_sum = {1'b0, s3_sqdx_r} + {1'b0, s3_sqdy_r};
  assign s3_hit   = s3_v_r && s3_ok_r && (dist_sum <= {1'b0, s3_sqr_r});
  assign s3_last  = s3_v_r && (s3_idx_r == LAST_IDX);
  assign scan_end = s3_hit || s3_last;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spcc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_chan.payload.operation == spcc_pkg::OP_QUERY) ? spcc_pkg::ST_SCAN
                                                                         : spcc_pkg::ST_RESP;
        end
      end
      spcc_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = spcc_pkg::ST_RESP;
        end
      end
      spcc_pkg::ST_RESP: begin
        if (load_out) begin
          state_nxt = spcc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spcc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_chan.ready = (state_r == spcc_pkg::ST_IDLE) && !q_valid_unused;
    load_out      = (state_r == spcc_pkg::ST_RESP) && (!out_valid_r || out_chan.ready);
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spcc_pkg::ST_IDLE;
      iss_act_r   <= 1'b0;
      iss_idx_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_chan.payload.operation == spcc_pkg::OP_QUERY) begin
        iss_act_r <= 1'b1;
        iss_idx_r <= '0;
      end else if (scan_end) begin
        iss_act_r <= 1'b0;
      end else if (iss_act_r) begin
        if (iss_idx_r == LAST_IDX) begin
          iss_act_r <= 1'b0;
        end else begin
          iss_idx_r <= iss_idx_r + 1'b1;
        end
      end
      // A hit flushes the younger entries still in flight.
      s1_v_r <= iss_act_r && !scan_end;
      s2_v_r <= s1_v_r && !scan_end;
      s3_v_r <= s2_v_r && !scan_end;
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.payload.operation == spcc_pkg::OP_WRITE) begin
      res_r <= '0;
    end else if (state_r == spcc_pkg::ST_SCAN && scan_end) begin
      res_r.hit      <= s3_hit;
      res_r.hit_slot <= s3_hit ? spcc_pkg::SLOT_W'(s3_idx_r) : '0;
    end
    if (load_out) begin
      out_data_r <= res_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.payload.hit |-> out_chan.payload.hit_slot == '0)
    else $error("result without a hit carries a nonzero slot");

  a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.payload.hit |->
      ({1'b0, out_chan.payload.hit_slot} < (spcc_pkg::SLOT_W + 1)'(MEM_DEPTH)))
    else $error("hit slot lies outside the table");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r || s2_v_r || s3_v_r |-> state_r == spcc_pkg::ST_SCAN)
    else $error("scan pipeline busy outside a query");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("second item taken while one is in progress");

endmodule
